@@ design/rab_pkg.sv @@
// Shared types and constants of the register, arithmetic and branch unit.
package rab_pkg;

    // Data word of the register file.
    localparam int DATA_W = 16;
    localparam int POS_W  = 24;

    // Item kinds.
    localparam logic FUNC_SET  = 1'b0;
    localparam logic FUNC_JUMP = 1'b1;

    // Set-register operation codes; unused codes act as store.
    localparam logic [3:0] OP_STORE = 4'd0;
    localparam logic [3:0] OP_ADD   = 4'd1;
    localparam logic [3:0] OP_SUB   = 4'd2;
    localparam logic [3:0] OP_MUL   = 4'd3;
    localparam logic [3:0] OP_DIV   = 4'd4;
    localparam logic [3:0] OP_MOD   = 4'd5;
    localparam logic [3:0] OP_RND   = 4'd6;
    localparam logic [3:0] OP_AND   = 4'd7;
    localparam logic [3:0] OP_OR    = 4'd8;
    localparam logic [3:0] OP_XOR   = 4'd9;

    // Jump condition codes; unused codes test for equal.
    localparam logic [3:0] COND_EQ        = 4'd0;
    localparam logic [3:0] COND_NE        = 4'd1;
    localparam logic [3:0] COND_GE        = 4'd2;
    localparam logic [3:0] COND_LE        = 4'd3;
    localparam logic [3:0] COND_GT        = 4'd4;
    localparam logic [3:0] COND_LT        = 4'd5;
    localparam logic [3:0] COND_CARRY_CLR = 4'd6;
    localparam logic [3:0] COND_CARRY_SET = 4'd7;
    localparam logic [3:0] COND_NEG_CLR   = 4'd8;
    localparam logic [3:0] COND_NEG_SET   = 4'd9;

    // One command request.
    typedef struct packed {
        logic              func;
        logic [7:0]        mode;
        logic [7:0]        dest_index;
        logic [DATA_W-1:0] first_operand;
        logic [DATA_W-1:0] second_operand;
        logic [POS_W-1:0]  target_true;
        logic [POS_W-1:0]  target_false;
        logic [DATA_W-1:0] random_value;
    } cmd_item_t;

    // One result request.
    typedef struct packed {
        logic [DATA_W-1:0] written_value;
        logic [7:0]        written_index;
        logic              carry_flag;
        logic              negative_flag;
        logic              jump_taken;
        logic [POS_W-1:0]  next_position;
    } res_item_t;

    // Status returned by the shared divider.
    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_result_t;

endpackage

@@ design/rab_if.sv @@
// Valid/ready channel interfaces for command and result requests.
interface rab_cmd_if
    import rab_pkg::*;
();
    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rab_res_if
    import rab_pkg::*;
();
    logic      valid;
    logic      ready;
    res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/register_alu_and_branch.sv @@
// Top level: register file, flags, shared ALU and divider under a small sequencer.
// Operand fetch: immediate (S_FETCH), direct (S_INDEX, S_READ, S_RDATA) or indirect (that
// sequence twice); then S_EXEC, S_DIV for divide, modulo or randomize by a nonzero divisor, S_DONE.
// A REG_COUNT that is not a power of two adds a divider pass (S_IDXDIV) per register index.
// One command at a time, taken in the cycle after the last result is loaded.
// Reset clears flags and base at once, then a pass over every index zeroes the register file.
module register_alu_and_branch
    import rab_pkg::*;
#(
    parameter int REG_COUNT = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [POS_W-1:0] cfg_wr_data,
    rab_cmd_if.sink          cmd,
    rab_res_if.source        result
);

    localparam int          AW      = $clog2(REG_COUNT);
    localparam bit          IS_POW2 = ((1 << AW) == REG_COUNT);
    localparam logic [DATA_W-1:0] REG_COUNT_W = DATA_W'(REG_COUNT);

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_FETCH  = 10'b0000000100,
        S_INDEX  = 10'b0000001000,
        S_IDXDIV = 10'b0000010000,
        S_READ   = 10'b0000100000,
        S_RDATA  = 10'b0001000000,
        S_EXEC   = 10'b0010000000,
        S_DIV    = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } state_t;

    typedef enum logic [3:0] {
        P_DEST = 4'b0001,
        P_SRC  = 4'b0010,
        P_A    = 4'b0100,
        P_B    = 4'b1000
    } phase_t;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic              carry_reg, carry_next;
    logic              neg_reg, neg_next;
    logic [POS_W-1:0]  base_reg, base_next;
    logic              out_valid_reg, out_valid_next;

    cmd_item_t         item_reg, item_next;
    logic [DATA_W-1:0] raw_reg, raw_next;
    logic [1:0]        kind_reg, kind_next;
    logic              ind_reg, ind_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     dest_reg, dest_next;
    logic [DATA_W-1:0] opa_reg, opa_next;
    logic [DATA_W-1:0] opb_reg, opb_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    logic              res_carry_reg, res_carry_next;
    logic              res_taken_reg, res_taken_next;
    logic [POS_W-1:0]  res_npos_reg, res_npos_next;
    res_item_t         out_data_reg, out_data_next;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [DATA_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [DATA_W-1:0] ram_rd_data;

    logic              div_start;
    logic [DATA_W-1:0] div_dividend;
    logic [DATA_W-1:0] div_divisor;
    div_result_t       div_res;

    logic              fetch_done;
    logic [DATA_W-1:0] fetch_value;
    logic              out_load;
    logic              taken;
    logic [3:0]        op;

    logic [DATA_W:0]     sum;
    logic [DATA_W:0]     diff;
    logic [2*DATA_W-1:0] prod;
    logic                a_eq_b;
    logic                a_lt_b;

    // Register file.
    rab_ram #(
        .WIDTH (DATA_W),
        .DEPTH (REG_COUNT)
    ) u_regfile (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (addr_reg),
        .rd_data (ram_rd_data)
    );

    // Shared divider for division, modulo, randomize and index reduction.
    rab_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

    // Shared arithmetic: add, subtract (also the comparator) and multiply.
    assign op     = item_reg.mode[3:0];
    assign sum    = {1'b0, opa_reg} + {1'b0, opb_reg};
    assign diff   = {1'b0, opa_reg} - {1'b0, opb_reg};
    assign prod   = opa_reg * opb_reg;
    assign a_eq_b = (opa_reg == opb_reg);
    assign a_lt_b = diff[DATA_W];

    // Jump condition.
    always_comb
    begin
        unique case (op)
            COND_NE:        taken = !a_eq_b;
            COND_GE:        taken = !a_lt_b;
            COND_LE:        taken = a_lt_b || a_eq_b;
            COND_GT:        taken = !a_lt_b && !a_eq_b;
            COND_LT:        taken = a_lt_b;
            COND_CARRY_CLR: taken = !carry_reg;
            COND_CARRY_SET: taken = carry_reg;
            COND_NEG_CLR:   taken = !neg_reg;
            COND_NEG_SET:   taken = neg_reg;
            default:        taken = a_eq_b;
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        clr_cnt_next   = clr_cnt_reg;
        carry_next     = carry_reg;
        neg_next       = neg_reg;
        base_next      = base_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        raw_next       = raw_reg;
        kind_next      = kind_reg;
        ind_next       = ind_reg;
        addr_next      = addr_reg;
        dest_next      = dest_reg;
        opa_next       = opa_reg;
        opb_next       = opb_reg;
        res_value_next = res_value_reg;
        res_carry_next = res_carry_reg;
        res_taken_next = res_taken_reg;
        res_npos_next  = res_npos_reg;
        out_data_next  = out_data_reg;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = dest_reg;
        ram_wr_data    = res_value_reg;
        ram_rd_en      = 1'b0;
        div_start      = 1'b0;
        div_dividend   = opa_reg;
        div_divisor    = opb_reg;
        fetch_done     = 1'b0;
        fetch_value    = ram_rd_data;
        out_load       = 1'b0;
        cmd.ready      = 1'b0;

        if (cfg_wr_en)
        begin
            base_next = cfg_wr_data;
        end

        // The result register empties when the sink takes it.
        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_cnt_reg;
                ram_wr_data = '0;
                if (clr_cnt_reg == AW'(REG_COUNT - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (cmd.valid)
                begin
                    item_next  = cmd.data;
                    state_next = S_FETCH;
                    if (cmd.data.func == FUNC_SET)
                    begin
                        // The destination is fetched like a register operand.
                        phase_next = P_DEST;
                        raw_next   = {8'b0, cmd.data.dest_index};
                        kind_next  = {1'b0, cmd.data.mode[6]};
                    end
                    else
                    begin
                        phase_next = P_A;
                        raw_next   = cmd.data.first_operand;
                        kind_next  = cmd.data.mode[7:6];
                    end
                end
            end
            S_FETCH:
            begin
                if (kind_reg[1])
                begin
                    // Immediate word or byte.
                    fetch_done  = 1'b1;
                    fetch_value = kind_reg[0] ? raw_reg : {8'b0, raw_reg[7:0]};
                end
                else
                begin
                    raw_next   = {8'b0, raw_reg[7:0]};
                    ind_next   = kind_reg[0];
                    state_next = S_INDEX;
                end
            end
            S_INDEX:
            begin
                if (IS_POW2)
                begin
                    addr_next  = raw_reg[AW-1:0];
                    state_next = S_READ;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = raw_reg;
                    div_divisor  = REG_COUNT_W;
                    state_next   = S_IDXDIV;
                end
            end
            S_IDXDIV:
            begin
                if (div_res.done)
                begin
                    addr_next  = AW'(div_res.remainder);
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                ram_rd_en  = 1'b1;
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                if (ind_reg)
                begin
                    // Indirect: the value just read is the next index.
                    raw_next   = ram_rd_data;
                    ind_next   = 1'b0;
                    state_next = S_INDEX;
                end
                else
                begin
                    fetch_done = 1'b1;
                end
            end
            S_EXEC:
            begin
                state_next     = S_DONE;
                res_carry_next = 1'b0;
                res_taken_next = taken;
                res_npos_next  = (taken ? item_reg.target_true : item_reg.target_false)
                                 - base_reg;
                if (item_reg.func == FUNC_SET)
                begin
                    unique case (op)
                        OP_ADD:
                        begin
                            res_value_next = sum[DATA_W-1:0];
                            res_carry_next = sum[DATA_W];
                        end
                        OP_SUB:
                        begin
                            res_value_next = diff[DATA_W-1:0];
                            res_carry_next = diff[DATA_W];
                        end
                        OP_MUL:
                        begin
                            // An overflowing product keeps its high half.
                            if (prod[2*DATA_W-1:DATA_W] != '0)
                            begin
                                res_value_next = prod[2*DATA_W-1:DATA_W];
                            end
                            else
                            begin
                                res_value_next = prod[DATA_W-1:0];
                            end
                        end
                        OP_DIV, OP_MOD:
                        begin
                            res_value_next = opa_reg;
                            if (opb_reg != '0)
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIV;
                            end
                        end
                        OP_RND:
                        begin
                            res_value_next = item_reg.random_value;
                            if (opb_reg != '0)
                            begin
                                div_start    = 1'b1;
                                div_dividend = item_reg.random_value;
                                state_next   = S_DIV;
                            end
                        end
                        OP_AND:  res_value_next = opa_reg & opb_reg;
                        OP_OR:   res_value_next = opa_reg | opb_reg;
                        OP_XOR:  res_value_next = opa_reg ^ opb_reg;
                        default: res_value_next = opb_reg;
                    endcase
                end
            end
            S_DIV:
            begin
                if (div_res.done)
                begin
                    res_value_next = (op == OP_DIV) ? div_res.quotient : div_res.remainder;
                    state_next     = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (item_reg.func == FUNC_SET)
                    begin
                        ram_wr_en  = 1'b1;
                        carry_next = res_carry_reg;
                        neg_next   = res_value_reg[DATA_W-1];
                        out_data_next.written_value = res_value_reg;
                        out_data_next.written_index = 8'(dest_reg);
                        out_data_next.carry_flag    = res_carry_reg;
                        out_data_next.negative_flag = res_value_reg[DATA_W-1];
                        out_data_next.jump_taken    = 1'b0;
                        out_data_next.next_position = '0;
                    end
                    else
                    begin
                        out_data_next.written_value = '0;
                        out_data_next.written_index = '0;
                        out_data_next.carry_flag    = carry_reg;
                        out_data_next.negative_flag = neg_reg;
                        out_data_next.jump_taken    = res_taken_reg;
                        out_data_next.next_position = res_npos_reg;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // A finished operand fetch moves on to the next operand or to execute.
        if (fetch_done)
        begin
            unique case (phase_reg)
                P_DEST:
                begin
                    opa_next   = fetch_value;
                    dest_next  = addr_reg;
                    phase_next = P_SRC;
                    raw_next   = item_reg.second_operand;
                    kind_next  = item_reg.mode[5:4];
                    state_next = S_FETCH;
                end
                P_A:
                begin
                    opa_next   = fetch_value;
                    phase_next = P_B;
                    raw_next   = item_reg.second_operand;
                    kind_next  = item_reg.mode[5:4];
                    state_next = S_FETCH;
                end
                P_SRC, P_B:
                begin
                    opb_next   = fetch_value;
                    state_next = S_EXEC;
                end
                default:
                begin
                    state_next = S_EXEC;
                end
            endcase
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            phase_reg     <= P_DEST;
            clr_cnt_reg   <= '0;
            carry_reg     <= 1'b0;
            neg_reg       <= 1'b0;
            base_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            clr_cnt_reg   <= clr_cnt_next;
            carry_reg     <= carry_next;
            neg_reg       <= neg_next;
            base_reg      <= base_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        raw_reg       <= raw_next;
        kind_reg      <= kind_next;
        ind_reg       <= ind_next;
        addr_reg      <= addr_next;
        dest_reg      <= dest_next;
        opa_reg       <= opa_next;
        opb_reg       <= opb_next;
        res_value_reg <= res_value_next;
        res_carry_reg <= res_carry_next;
        res_taken_reg <= res_taken_next;
        res_npos_reg  <= res_npos_next;
        out_data_reg  <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_IDXDIV || state_reg == S_DIV))
    else $error("divider finished outside a wait state");

    // A jump leaves the status flags as they were.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && item_reg.func == FUNC_JUMP) |=> $stable({carry_reg, neg_reg}))
    else $error("jump changed the status flags");

    // Divide, modulo or randomize by zero skips the divider.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && item_reg.func == FUNC_SET && opb_reg == '0 &&
         (op == OP_DIV || op == OP_MOD || op == OP_RND)) |=> state_reg == S_DONE)
    else $error("zero divisor reached the divider");

endmodule

@@ design/rab_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module rab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ design/rab_div.sv @@
// Restoring 16-bit divider, one quotient bit per cycle.
module rab_div
    import rab_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DATA_W-1:0] dividend,
    input  logic [DATA_W-1:0] divisor,
    output div_result_t       res
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    // One trial subtraction of the shifted partial remainder.
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (shifted >= {1'b0, dvs_reg})
            begin
                rem_next = trial[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = quo_reg;
    assign res.remainder = rem_reg;

endmodule
